// ===== hw/rtl/bpr_pkg.sv =====
// Shared types, codes and default sizes for the block part reassembler.
package bpr_pkg;

    localparam int DEF_PART_BYTES  = 99;
    localparam int DEF_MAX_PARTS   = 42;
    localparam int DEF_BLOCK_BYTES = 4096;

    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 13;
    localparam int RADDR_W = 13;

    localparam logic [1:0] OP_ARM   = 2'd0;
    localparam logic [1:0] OP_PART  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [1:0] KIND_PART  = 2'd0;
    localparam logic [1:0] KIND_CHECK = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [2:0] RSN_OK    = 3'd0;
    localparam logic [2:0] RSN_ID    = 3'd1;
    localparam logic [2:0] RSN_RANGE = 3'd2;
    localparam logic [2:0] RSN_SUM   = 3'd3;
    localparam logic [2:0] RSN_LEN   = 3'd4;

    localparam logic REG_BLOCK_ID   = 1'b0;
    localparam logic REG_BYTE_COUNT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_COPY,
        S_HDR,
        S_SUM,
        S_OUT
    } state_t;

endpackage

// ===== hw/rtl/bpr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module bpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/block_part_reassembler.sv =====
// Block part reassembler: rebuilds one data block from fixed-size radio parts.
//
// The input stream carries one transaction per item: tuser is the operation (arm, part
// byte, completion check, buffer read), tlast marks the final byte of a part. Arm and
// non-final part bytes give no result. A final part byte gives a part verdict, a check
// gives a check verdict, and a read returns one buffer byte on the output stream.
// The block takes one item at a time. An arm or a non-final part byte leaves it idle.
// A read goes through the buffer read and then waits for the output handshake.
// A rejected part is answered in the cycle after it ends; an accepted one first copies
// its data from the staging RAM into the block buffer, one byte a cycle. A check of a
// complete block walks the header and payload through the buffer read port.
// Reset clears the missing bitmap, the part counters and the registers (block id 0,
// byte count BLOCK_BYTES); buffer contents are not cleared. While the receiver stalls,
// the result holds on the output and no new input transaction is taken. The user must
// write registers through the APB port only while idle; the block does not enforce it.
module block_part_reassembler
    import bpr_pkg::*;
#(
    parameter int PART_BYTES  = DEF_PART_BYTES,
    parameter int MAX_PARTS   = DEF_MAX_PARTS,
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
    localparam int OUT_W      = ((22 + MAX_PARTS + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // data_byte, read_address
    input  logic [1:0]        s_tuser,   // op
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // reject_reason, part_number, block_complete,
                                         // block_valid, request_partial, missing_parts,
                                         // read_data
    output logic [1:0]        m_tuser,   // result_kind
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int BUF_BYTES = BLOCK_BYTES + 4;
    localparam int BUF_AW    = $clog2(BUF_BYTES);
    localparam int PART_LEN  = PART_BYTES + 3;
    localparam int POS_W     = $clog2(PART_LEN + 2);
    localparam int STG_AW    = $clog2(PART_BYTES);
    localparam int LEFT_W    = $clog2(BLOCK_BYTES + 1);
    localparam logic [15:0] PSTEP = 16'(PART_BYTES);

    state_t state_reg, state_next;
    logic [7:0]           exp_id_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [MAX_PARTS-1:0] miss_reg, miss_next;
    logic [MAX_PARTS-1:0] exp_reg, exp_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [7:0]           sum_reg, sum_next;
    logic [7:0]           hsum_reg, hsum_next;
    logic [7:0]           hid_reg, hid_next;
    logic [7:0]           hidx_reg, hidx_next;
    logic                 partial_reg, partial_next;
    logic [BUF_AW-1:0]    addr_reg, addr_next;
    logic [BUF_AW-1:0]    waddr_reg, waddr_next;
    logic [STG_AW-1:0]    sidx_reg, sidx_next;
    logic [LEFT_W-1:0]    left_reg, left_next;
    logic                 pend_reg, pend_next;
    logic [1:0]           pidx_reg, pidx_next;
    logic [31:0]          hdr_reg, hdr_next;
    logic [15:0]          total_reg, total_next;
    logic                 oob_reg, oob_next;

    logic [1:0]           kind_reg, kind_next;
    logic [2:0]           rsn_reg, rsn_next;
    logic [7:0]           pnum_reg, pnum_next;
    logic                 cmp_reg, cmp_next;
    logic                 val_reg, val_next;
    logic                 prt_reg, prt_next;
    logic [MAX_PARTS-1:0] mout_reg, mout_next;
    logic [7:0]           rdat_reg, rdat_next;

    logic                 buf_we;
    logic [BUF_AW-1:0]    buf_raddr;
    logic [7:0]           buf_rdata;
    logic                 stg_we;
    logic [STG_AW-1:0]    stg_waddr;
    logic [STG_AW-1:0]    stg_raddr;
    logic [7:0]           stg_rdata;

    logic [1:0]           in_op;
    logic [7:0]           in_byte;
    logic [RADDR_W-1:0]   in_addr;
    logic                 in_acc;
    logic                 cfg_wr;
    logic                 sweep_done;
    logic                 complete;
    logic [2:0]           verdict;
    logic [15:0]          start_w;
    logic                 range_bad;
    logic                 clip;
    logic [LEFT_W-1:0]    cp_len;
    logic [15:0]          x_plus4;
    logic [MAX_PARTS-1:0] arm_mask;
    logic [MAX_PARTS-1:0] clr_mask;
    logic                 size_bad;

    assign in_op   = s_tuser;
    assign in_byte = s_tdata[7:0];
    assign in_addr = s_tdata[20:8];
    assign in_acc  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_BYTE_COUNT) ? {{(32 - CNT_W){1'b0}}, count_reg}
                                                  : {24'd0, exp_id_reg};

    // Part header tracking; verdict uses the values as they stand after this byte.
    always_comb
    begin
        hsum_next = hsum_reg;
        hid_next  = hid_reg;
        hidx_next = hidx_reg;
        sum_next  = sum_reg;
        if (pos_reg == '0)
        begin
            hsum_next = in_byte;
        end
        else
        begin
            sum_next = sum_reg + in_byte;
            if (pos_reg == POS_W'(1))
            begin
                hid_next = in_byte;
            end
            else if (pos_reg == POS_W'(2))
            begin
                hidx_next = in_byte;
            end
        end
        pos_next = (pos_reg < POS_W'(PART_LEN + 1)) ? pos_reg + POS_W'(1) : pos_reg;
    end

    assign stg_we    = in_acc && (in_op == OP_PART) && (pos_reg >= POS_W'(3))
                       && (pos_reg < POS_W'(PART_LEN));
    assign stg_waddr = STG_AW'(pos_reg - POS_W'(3));

    assign start_w   = 16'({8'd0, hidx_next} * PSTEP);
    assign range_bad = (17'(start_w) >= 17'(BUF_BYTES - 1)) || (hidx_next > 8'(MAX_PARTS));
    assign clip      = (17'(start_w) + 17'(PART_BYTES)) > 17'(BUF_BYTES);
    assign cp_len    = clip ? LEFT_W'(17'(BUF_BYTES) - 17'(start_w)) : LEFT_W'(PART_BYTES);

    always_comb
    begin
        if (pos_next != POS_W'(PART_LEN))
        begin
            verdict = RSN_LEN;
        end
        else if (hid_next != exp_id_reg)
        begin
            verdict = RSN_ID;
        end
        else if (range_bad)
        begin
            verdict = RSN_RANGE;
        end
        else if (sum_next != hsum_next)
        begin
            verdict = RSN_SUM;
        end
        else
        begin
            verdict = RSN_OK;
        end
    end

    // Parts k with k * PART_BYTES below 4 + byte count are expected; all at BLOCK_BYTES.
    assign x_plus4 = 16'(count_reg) + 16'd4;
    always_comb
    begin
        for (int k = 0; k < MAX_PARTS; k++)
        begin
            arm_mask[k] = (count_reg == CNT_W'(BLOCK_BYTES)) || (16'(k * PART_BYTES) < x_plus4);
            clr_mask[k] = (hidx_next == 8'(k));
        end
    end

    assign complete   = (miss_reg & exp_reg) == '0;
    assign sweep_done = (left_reg == '0) && !pend_reg;
    assign size_bad   = hdr_reg[15:0] > 16'(BLOCK_BYTES);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (in_op)
                        OP_ARM:   state_next = S_IDLE;
                        OP_PART:
                        begin
                            if (s_tlast)
                            begin
                                state_next = (verdict == RSN_OK) ? S_COPY : S_OUT;
                            end
                        end
                        OP_CHECK: state_next = complete ? S_HDR : S_OUT;
                        OP_READ:  state_next = S_READ;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_READ: state_next = S_OUT;
            S_COPY:
            begin
                if (sweep_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_HDR:
            begin
                if (sweep_done)
                begin
                    state_next = size_bad ? S_OUT : S_SUM;
                end
            end
            S_SUM:
            begin
                if (sweep_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and result registers.
    always_comb
    begin
        miss_next    = miss_reg;
        exp_next     = exp_reg;
        partial_next = partial_reg;
        addr_next    = addr_reg;
        waddr_next   = waddr_reg;
        sidx_next    = sidx_reg;
        left_next    = left_reg;
        pend_next    = 1'b0;
        pidx_next    = pidx_reg;
        hdr_next     = hdr_reg;
        total_next   = total_reg;
        oob_next     = oob_reg;
        kind_next    = kind_reg;
        rsn_next     = rsn_reg;
        pnum_next    = pnum_reg;
        cmp_next     = cmp_reg;
        val_next     = val_reg;
        prt_next     = prt_reg;
        mout_next    = mout_reg;
        rdat_next    = rdat_reg;
        buf_we       = 1'b0;
        buf_raddr    = addr_reg;
        stg_raddr    = sidx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                buf_raddr = BUF_AW'(in_addr);
                if (in_acc)
                begin
                    rsn_next  = RSN_OK;
                    pnum_next = 8'd0;
                    cmp_next  = 1'b0;
                    val_next  = 1'b0;
                    prt_next  = 1'b0;
                    mout_next = '0;
                    rdat_next = 8'd0;
                    unique case (in_op)
                        OP_ARM:
                        begin
                            miss_next    = arm_mask;
                            exp_next     = arm_mask;
                            partial_next = 1'b0;
                        end
                        OP_PART:
                        begin
                            kind_next = KIND_PART;
                            if (s_tlast)
                            begin
                                rsn_next  = verdict;
                                pnum_next = hidx_next;
                                if (verdict == RSN_OK)
                                begin
                                    miss_next  = miss_reg & ~clr_mask;
                                    waddr_next = BUF_AW'(start_w);
                                    sidx_next  = '0;
                                    left_next  = cp_len;
                                end
                                mout_next = (verdict == RSN_OK) ? (miss_reg & ~clr_mask)
                                                                : miss_reg;
                            end
                        end
                        OP_CHECK:
                        begin
                            kind_next = KIND_CHECK;
                            if (complete)
                            begin
                                cmp_next  = 1'b1;
                                addr_next = '0;
                                left_next = LEFT_W'(4);
                            end
                            else
                            begin
                                partial_next = 1'b1;
                                prt_next     = 1'b1;
                                mout_next    = miss_reg;
                            end
                        end
                        OP_READ:
                        begin
                            kind_next = KIND_READ;
                            oob_next  = 17'(in_addr) >= 17'(BUF_BYTES);
                        end
                        default:
                        begin
                            kind_next = KIND_READ;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rdat_next = oob_reg ? 8'd0 : buf_rdata;
            end
            S_COPY:
            begin
                if (left_reg != '0)
                begin
                    sidx_next = sidx_reg + STG_AW'(1);
                    left_next = left_reg - LEFT_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    buf_we     = 1'b1;
                    waddr_next = waddr_reg + BUF_AW'(1);
                end
            end
            S_HDR:
            begin
                if (left_reg != '0)
                begin
                    addr_next = addr_reg + BUF_AW'(1);
                    left_next = left_reg - LEFT_W'(1);
                    pend_next = 1'b1;
                    pidx_next = addr_reg[1:0];
                end
                if (pend_reg)
                begin
                    hdr_next[8 * pidx_reg +: 8] = buf_rdata;
                end
                if (sweep_done)
                begin
                    if (size_bad)
                    begin
                        miss_next    = miss_reg | exp_reg;
                        partial_next = 1'b0;
                        mout_next    = miss_reg | exp_reg;
                    end
                    else
                    begin
                        addr_next  = BUF_AW'(4);
                        left_next  = LEFT_W'(hdr_reg[15:0]);
                        total_next = 16'd0;
                    end
                end
            end
            S_SUM:
            begin
                if (left_reg != '0)
                begin
                    addr_next = addr_reg + BUF_AW'(1);
                    left_next = left_reg - LEFT_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    total_next = total_reg + 16'(buf_rdata);
                end
                if (sweep_done)
                begin
                    if (total_reg == hdr_reg[31:16])
                    begin
                        val_next  = 1'b1;
                        prt_next  = partial_reg;
                        mout_next = miss_reg;
                    end
                    else
                    begin
                        miss_next    = miss_reg | exp_reg;
                        partial_next = 1'b0;
                        mout_next    = miss_reg | exp_reg;
                    end
                end
            end
            S_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            exp_id_reg  <= 8'd0;
            count_reg   <= CNT_W'(BLOCK_BYTES);
            miss_reg    <= '0;
            exp_reg     <= '0;
            pos_reg     <= '0;
            sum_reg     <= 8'd0;
            hsum_reg    <= 8'd0;
            hid_reg     <= 8'd0;
            hidx_reg    <= 8'd0;
            partial_reg <= 1'b0;
            left_reg    <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            miss_reg    <= miss_next;
            exp_reg     <= exp_next;
            partial_reg <= partial_next;
            left_reg    <= left_next;
            pend_reg    <= pend_next;
            if (cfg_wr)
            begin
                if (paddr[2] == REG_BLOCK_ID)
                begin
                    exp_id_reg <= pwdata[7:0];
                end
                else
                begin
                    count_reg <= pwdata[CNT_W-1:0];
                end
            end
            if (in_acc && (in_op == OP_PART))
            begin
                hsum_reg <= hsum_next;
                hid_reg  <= hid_next;
                hidx_reg <= hidx_next;
                if (s_tlast)
                begin
                    pos_reg <= '0;
                    sum_reg <= 8'd0;
                end
                else
                begin
                    pos_reg <= pos_next;
                    sum_reg <= sum_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        waddr_reg <= waddr_next;
        sidx_reg  <= sidx_next;
        pidx_reg  <= pidx_next;
        hdr_reg   <= hdr_next;
        total_reg <= total_next;
        oob_reg   <= oob_next;
        kind_reg  <= kind_next;
        rsn_reg   <= rsn_next;
        pnum_reg  <= pnum_next;
        cmp_reg   <= cmp_next;
        val_reg   <= val_next;
        prt_reg   <= prt_next;
        mout_reg  <= mout_next;
        rdat_reg  <= rdat_next;
    end

    assign m_tuser = kind_reg;
    assign m_tdata = OUT_W'({rdat_reg, mout_reg, prt_reg, val_reg, cmp_reg, pnum_reg, rsn_reg});

    bpr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_block_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (waddr_reg),
        .wdata (stg_rdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    bpr_ram #(
        .WIDTH (8),
        .DEPTH (PART_BYTES)
    ) u_staging (
        .clk   (clk),
        .we    (stg_we),
        .waddr (stg_waddr),
        .wdata (in_byte),
        .raddr (stg_raddr),
        .rdata (stg_rdata)
    );

`ifndef SYNTHESIS
    // Input and output sides never run at the same time.
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // Only expected parts can ever be marked missing.
    a_miss_in_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (miss_reg & ~exp_reg) == '0)
        else $error("missing bit set outside the expected parts");

    // The byte position saturates just past a full-length part.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(PART_LEN + 1))
        else $error("byte position out of range");

    // A buffer write happens only while copying a staged part.
    a_write_copy: assert property (@(posedge clk) disable iff (!rst_n)
        buf_we |-> (state_reg == S_COPY) && $past(state_reg == S_COPY || state_reg == S_IDLE))
        else $error("buffer write outside a part copy");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for block_part_reassembler: streamed part traffic against a predictor.
module tb;
    import bpr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PB = DEF_PART_BYTES;
    localparam int MP = DEF_MAX_PARTS;
    localparam int BB = DEF_BLOCK_BYTES;
    localparam int BUF_N = BB + 4;
    localparam int FLAW_NONE  = 0;
    localparam int FLAW_ID    = 1;
    localparam int FLAW_INDEX = 2;
    localparam int FLAW_SUM   = 3;
    localparam int FLAW_SHORT = 4;
    localparam int FLAW_LONG  = 5;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data;
        logic        last;
        logic [12:0] addr;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  reason;
        logic [7:0]  part;
        logic        complete;
        logic        valid;
        logic        partial;
        logic [41:0] missing;
        logic [7:0]  rdata;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    block_part_reassembler dut (.*);

    always #10 clk = ~clk;

    // Model state of the block.
    logic [7:0]  blk_mem [BUF_N];
    bit          blk_written [BUF_N];
    logic [7:0]  stage_mem [PB];
    logic [41:0] missing_map;
    int          parts_due;
    int          byte_pos;
    logic [7:0]  sum_acc;
    logic [7:0]  hdr_sum;
    logic [7:0]  hdr_id;
    logic [7:0]  hdr_idx;
    bit          partial_req;
    logic [7:0]  cfg_id;
    int          cfg_count;

    item_t       pending_items[$];
    verdict_t    expected_verdicts[$];
    item_t       cur_item;
    int          send_idle;
    int          recv_stall;
    int          errors;
    int          pushed;
    logic [7:0]  part_data [PB];
    logic [7:0]  image [BUF_N];

    task automatic report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic logic [41:0] low_bits(input int n);
        logic [41:0] m;
        m = '0;
        for (int i = 0; i < n && i < 42; i++)
            m[i] = 1'b1;
        return m;
    endfunction

    function automatic int hdr_size();
        return int'(blk_mem[0]) | (int'(blk_mem[1]) << 8);
    endfunction

    function automatic bit block_done();
        return (missing_map & low_bits(parts_due)) == '0;
    endfunction

    // A check of a complete block walks its header and payload, so all of it must be written.
    function automatic bit check_readable();
        int sz;
        if (!block_done())
            return 1'b1;
        for (int i = 0; i < 4; i++)
            if (!blk_written[i])
                return 1'b0;
        sz = hdr_size();
        if (sz > BB)
            return 1'b1;
        for (int i = 0; i < sz; i++)
            if (!blk_written[4 + i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit header_ok();
        int sz;
        logic [15:0] total;
        sz = hdr_size();
        total = '0;
        if (sz > BB)
            return 1'b0;
        for (int i = 0; i < sz; i++)
            total += 16'(blk_mem[4 + i]);
        return total == {blk_mem[3], blk_mem[2]};
    endfunction

    function automatic logic [2:0] judge();
        int start;
        start = int'(hdr_idx) * PB;
        if (byte_pos != PB + 3)
            return RSN_LEN;
        if (hdr_id != cfg_id)
            return RSN_ID;
        if (start >= BUF_N - 1 || hdr_idx > MP)
            return RSN_RANGE;
        if (sum_acc != hdr_sum)
            return RSN_SUM;
        for (int k = 0; k < PB && start + k < BUF_N; k++)
        begin
            blk_mem[start + k] = stage_mem[k];
            blk_written[start + k] = 1'b1;
        end
        if (hdr_idx < 42)
            missing_map[hdr_idx] = 1'b0;
        return RSN_OK;
    endfunction

    task automatic apply_item(input item_t it);
        verdict_t v;
        int n;
        bit full;
        v = '0;
        case (it.op)
            OP_ARM:
            begin
                if (cfg_count == BB)
                    n = MP;
                else
                    n = (4 + cfg_count + PB - 1) / PB;
                if (n > MP)
                    n = MP;
                parts_due = n;
                missing_map = low_bits(n);
                partial_req = 1'b0;
            end
            OP_PART:
            begin
                if (byte_pos == 0)
                    hdr_sum = it.data;
                else
                begin
                    sum_acc += it.data;
                    if (byte_pos == 1)
                        hdr_id = it.data;
                    else if (byte_pos == 2)
                        hdr_idx = it.data;
                    else if (byte_pos - 3 < PB)
                        stage_mem[byte_pos - 3] = it.data;
                end
                if (byte_pos < PB + 4)
                    byte_pos++;
                if (it.last)
                begin
                    v.kind = KIND_PART;
                    v.reason = judge();
                    v.part = hdr_idx;
                    v.missing = missing_map;
                    byte_pos = 0;
                    sum_acc = '0;
                    expected_verdicts.push_back(v);
                end
            end
            OP_CHECK:
            begin
                full = block_done();
                v.kind = KIND_CHECK;
                v.complete = full;
                if (full)
                begin
                    v.valid = header_ok();
                    if (!v.valid)
                    begin
                        missing_map |= low_bits(parts_due);
                        partial_req = 1'b0;
                    end
                end
                else
                    partial_req = 1'b1;
                v.partial = partial_req;
                v.missing = missing_map;
                expected_verdicts.push_back(v);
            end
            default:
            begin
                v.kind = KIND_READ;
                v.rdata = (it.addr < BUF_N) ? blk_mem[it.addr] : 8'h00;
                expected_verdicts.push_back(v);
            end
        endcase
    endtask

    // Driver: the model state is current at each pop, so unsafe checks are dropped here.
    always @(posedge clk)
    begin : drive_input
        item_t nx;
        bit got;
        got = 1'b0;
        if (s_tvalid && s_tready)
            apply_item(cur_item);
        if (!s_tvalid || s_tready)
        begin
            if (rst_n && $urandom_range(99) >= send_idle)
            begin
                while (!got && pending_items.size() > 0)
                begin
                    nx = pending_items.pop_front();
                    if (nx.op == OP_READ && nx.addr < BUF_N && !blk_written[nx.addr])
                        nx.addr = 13'($urandom_range(8191, BUF_N));
                    if (!(nx.op == OP_CHECK && !check_readable()))
                        got = 1'b1;
                end
            end
            if (got)
            begin
                s_tvalid <= 1'b1;
                cur_item <= nx;
                s_tdata <= {3'b000, nx.addr, nx.data};
                s_tuser <= nx.op;
                s_tlast <= nx.last;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    always @(posedge clk)
    begin : watch_output
        verdict_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_verdicts.size() == 0)
                report($sformatf("unexpected result tuser=%0d tdata=%h", m_tuser, m_tdata));
            else
            begin
                w = expected_verdicts.pop_front();
                if (m_tuser !== w.kind)
                    report($sformatf("kind %0d, want %0d", m_tuser, w.kind));
                if (m_tdata[2:0] !== w.reason)
                    report($sformatf("reason %0d, want %0d", m_tdata[2:0], w.reason));
                if (m_tdata[10:3] !== w.part)
                    report($sformatf("part %0d, want %0d", m_tdata[10:3], w.part));
                if (m_tdata[11] !== w.complete)
                    report($sformatf("complete %b, want %b", m_tdata[11], w.complete));
                if (m_tdata[12] !== w.valid)
                    report($sformatf("valid %b, want %b", m_tdata[12], w.valid));
                if (m_tdata[13] !== w.partial)
                    report($sformatf("partial %b, want %b", m_tdata[13], w.partial));
                if (m_tdata[55:14] !== w.missing)
                    report($sformatf("missing %h, want %h", m_tdata[55:14], w.missing));
                if (m_tdata[63:56] !== w.rdata)
                    report($sformatf("read %h, want %h", m_tdata[63:56], w.rdata));
            end
        end
    end

    task automatic push(input logic [1:0] op, input logic [7:0] data, input bit last,
                        input logic [12:0] addr);
        item_t it;
        it.op = op;
        it.data = data;
        it.last = last;
        it.addr = addr;
        pending_items.push_back(it);
        pushed++;
    endtask

    task automatic push_read(input int addr);
        push(OP_READ, 8'($urandom), 1'b0, 13'(addr));
    endtask

    // Random item that is not a part byte, used as noise inside and between parts.
    task automatic push_noise();
        case ($urandom_range(3))
            0: push_read($urandom_range(8191));
            1: push(OP_CHECK, 8'($urandom), 1'b0, 13'($urandom));
            default: push_read($urandom_range(cfg_count + 3));
        endcase
    endtask

    task automatic send_part(input logic [7:0] id, input logic [7:0] idx, input int flaw);
        logic [7:0] sum;
        int n;
        sum = id + idx;
        for (int k = 0; k < PB; k++)
            sum += part_data[k];
        if (flaw == FLAW_SUM)
            sum += 8'($urandom_range(255, 1));
        n = (flaw == FLAW_SHORT) ? PB - $urandom_range(PB, 1) :
            (flaw == FLAW_LONG) ? PB + $urandom_range(3, 1) : PB;
        push(OP_PART, sum, 1'b0, 13'($urandom));
        push(OP_PART, id, 1'b0, 13'($urandom));
        push(OP_PART, idx, n == 0, 13'($urandom));
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(49) == 0)
                push_noise();
            push(OP_PART, part_data[k % PB], k == n - 1, 13'($urandom));
        end
    endtask

    function automatic void load_part(input int idx);
        for (int k = 0; k < PB; k++)
            part_data[k] = (idx * PB + k < BUF_N) ? image[idx * PB + k] : 8'($urandom);
    endfunction

    // Payload of random bytes behind a size and sum header; the header is sometimes wrong.
    function automatic void build_image(input int count, input bit spoil);
        logic [15:0] total;
        total = '0;
        for (int i = 0; i < BUF_N; i++)
            image[i] = 8'($urandom);
        for (int i = 0; i < count; i++)
            total += 16'(image[4 + i]);
        if (spoil && $urandom_range(1))
            total += 16'($urandom_range(65535, 1));
        else if (spoil)
            count = $urandom_range(8191, 0);
        {image[1], image[0]} = 16'(count);
        {image[3], image[2]} = total;
    endfunction

    task automatic settle();
        while (pending_items.size() > 0 || s_tvalid || expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic apb_write(input logic reg_sel, input int value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == REG_BLOCK_ID)
            cfg_id = 8'(value);
        else
            cfg_count = value & 16'h1FFF;
    endtask

    task automatic set_mode(input int mode);
        send_idle = (mode == 1) ? 86 : (mode == 3) ? 15 : 0;
        recv_stall = (mode == 2) ? 86 : (mode == 3) ? 15 : 0;
    endtask

    // One fetch of a block: arm, parts in random order with some flaws, check, reads, check.
    task automatic fetch_block(input int count);
        int nparts;
        int order[$];
        int flaw;
        int j;
        logic [7:0] idx;
        nparts = (count == BB) ? MP : (4 + count + PB - 1) / PB;
        if (nparts > MP)
            nparts = MP;
        build_image(count, $urandom_range(6) == 0);
        push(OP_ARM, 8'($urandom), 1'($urandom), 13'($urandom));
        for (int i = 0; i < nparts; i++)
            order.push_back(i);
        order.shuffle();
        // A large block only gets a few parts so the run stays short.
        if (nparts > 4)
            order = order[0:2];
        foreach (order[i])
        begin
            flaw = ($urandom_range(99) < 75) ? FLAW_NONE : $urandom_range(FLAW_LONG, FLAW_ID);
            idx = (flaw == FLAW_INDEX) ? 8'($urandom_range(255, MP)) : 8'(order[i]);
            load_part(order[i]);
            send_part((flaw == FLAW_ID) ? cfg_id ^ 8'($urandom_range(255, 1)) : cfg_id,
                      idx, flaw);
            if (flaw != FLAW_NONE && $urandom_range(1))
                send_part(cfg_id, 8'(order[i]), FLAW_NONE);
            if ($urandom_range(3) == 0)
                push_noise();
        end
        if ($urandom_range(4) == 0 && order.size() > 0)
        begin
            j = order[0];
            load_part(j);
            send_part(cfg_id, 8'(j), FLAW_NONE);
        end
        push(OP_CHECK, 8'($urandom), 1'($urandom), 13'($urandom));
        for (int i = 0; i < 4; i++)
            push_read($urandom_range(count + 3));
        push(OP_CHECK, 8'($urandom), 1'($urandom), 13'($urandom));
    endtask

    initial
    begin : stimulus
        int session;
        int count;
        errors = 0;
        pushed = 0;
        missing_map = '0;
        parts_due = 0;
        byte_pos = 0;
        sum_acc = '0;
        hdr_sum = '0;
        hdr_id = '0;
        hdr_idx = '0;
        partial_req = 1'b0;
        cfg_id = '0;
        cfg_count = BB;
        for (int i = 0; i < BUF_N; i++)
        begin
            blk_mem[i] = '0;
            blk_written[i] = 1'b0;
        end
        set_mode(0);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: extreme registers, every rejection, clipping and out-of-range reads.
        apb_write(REG_BLOCK_ID, 255);
        apb_write(REG_BYTE_COUNT, 0);
        push_read(BUF_N);
        push_read(8191);
        push(OP_ARM, 8'hFF, 1'b1, 13'h1FFF);
        build_image(0, 1'b0);
        load_part(0);
        send_part(8'd255, 8'd0, FLAW_NONE);
        push(OP_CHECK, 8'h00, 1'b0, 13'h0000);
        push_read(0);
        push_read(3);
        send_part(8'd0, 8'd0, FLAW_ID);
        send_part(8'd255, 8'd42, FLAW_NONE);
        send_part(8'd255, 8'd255, FLAW_NONE);
        send_part(8'd255, 8'd0, FLAW_SUM);
        send_part(8'd255, 8'd0, FLAW_SHORT);
        send_part(8'd255, 8'd0, FLAW_LONG);
        push(OP_PART, 8'h00, 1'b1, 13'h0000);
        settle();
        apb_write(REG_BLOCK_ID, 0);
        apb_write(REG_BYTE_COUNT, BB);
        push(OP_ARM, 8'h00, 1'b0, 13'h0000);
        build_image(BB, 1'b0);
        load_part(MP - 1);
        send_part(8'd0, 8'(MP - 1), FLAW_NONE);
        push_read(BUF_N - 1);
        push(OP_CHECK, 8'h00, 1'b0, 13'h0000);
        settle();

        // Random sessions; every one starts from an idle block.
        session = 0;
        while (pushed < 1800)
        begin
            set_mode(session % 4);
            apb_write(REG_BLOCK_ID, $urandom_range(255));
            case ($urandom_range(9))
                0: count = BB;
                1: count = $urandom_range(BB - 1, 3000);
                2: count = 0;
                default: count = $urandom_range(300);
            endcase
            apb_write(REG_BYTE_COUNT, count);
            fetch_block(count);
            settle();
            session++;
        end

        while (expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : run_limit
        #(20ms);
        $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/bpr_pkg.sv
hw/rtl/bpr_ram.sv
hw/rtl/block_part_reassembler.sv
sim/tb.sv
